// ----- rtl/windowed_drift_calibration_monitor_assert.svh -----
// Assertion macros shared by the drift monitor RTL.
`ifndef WINDOWED_DRIFT_CALIBRATION_MONITOR_ASSERT_SVH
`define WINDOWED_DRIFT_CALIBRATION_MONITOR_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define WDCM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wdcm assertion failed");

// Next-cycle implication, held off during reset.
`define WDCM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wdcm assertion failed");

`endif

// ----- rtl/wdcm_pkg.sv -----
// Shared types and constants of the drift monitor.
package wdcm_pkg;
    localparam int CONF_W   = 17;
    localparam int DIV_W    = 24;
    localparam int FILL_W   = 9;
    localparam int SAMPLE_W = CONF_W + 1 + DIV_W;
    localparam int CFG_W    = 24;
    localparam int IN_TW    = 48;
    localparam int OUT_TW   = 80;
    localparam int ONE_Q16  = 65536;
    localparam int ALERT_MIN_FILL = 50;

    localparam logic [1:0] REG_CAL_LIMIT = 2'd0;
    localparam logic [1:0] REG_DIV_LIMIT = 2'd1;
    localparam logic [1:0] REG_DIV_CRIT  = 2'd2;

    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_CAL    = 2'd1;
    localparam logic [1:0] ACT_FREEZE = 2'd2;
    localparam logic [1:0] ACT_EMERG  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVICT,
        S_ADD,
        S_ECE,
        S_SCAN,
        S_DSTART,
        S_DWAIT,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        OP_ECE,
        OP_MEAN
    } t_dop;
endpackage

// ----- rtl/wdcm_div.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
module wdcm_div #(
    parameter int NW = 34,
    parameter int DW = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [NW-1:0] o_quotient
);
    localparam int CW = $clog2(NW + 1);

    logic [DW-1:0] r_dvs;
    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_quo;
    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic [DW:0]   w_sh;
    logic          w_ge;

    assign w_sh = {r_rem, r_quo[NW-1]};
    assign w_ge = w_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(NW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? DW'(w_sh - {1'b0, r_dvs}) : w_sh[DW-1:0];
            r_quo <= {r_quo[NW-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

// ----- rtl/windowed_drift_calibration_monitor.sv -----
// Top level of the windowed drift and calibration monitor.
// Each item is one scored sample and gives exactly one result item. Samples live in a
// WINDOW-deep single-port ring memory; per-bin sums sit in small register files. An item
// is accepted in S_IDLE, then S_EVICT writes it to the ring and, once the window is full,
// takes the evicted sample out of the sums, and S_ADD adds it to the sums. S_ECE walks
// the NUM_BINS bins for the calibration error sum, S_SCAN rescans the ring for the maximum
// divergence (one memory read per cycle), S_DSTART and S_DWAIT run two serial divisions by
// the fill (one quotient bit per cycle on a 34-bit dividend), and S_OUT loads the output
// register. The baseline comes from a constant reciprocal multiply with no state of its
// own. A finished result waits in an output register while the next item is accepted.
`include "windowed_drift_calibration_monitor_assert.svh"
module windowed_drift_calibration_monitor #(
    parameter int WINDOW          = 500,
    parameter int BASELINE_LENGTH = 100,
    parameter int NUM_BINS        = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // confidence[16:0], was_positive[17], divergence[41:18], zero pad
    input  logic [wdcm_pkg::IN_TW-1:0]    s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // action_level[1:0], needs_calibration[2], freeze_flag[3], spike_flag[4],
    // baseline_ready[5], calibration_error[22:6], mean_divergence[46:23],
    // max_divergence[70:47], fill_level[79:71]
    output logic [wdcm_pkg::OUT_TW-1:0]   m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [wdcm_pkg::CFG_W-1:0]    i_cfg_data
);
    import wdcm_pkg::*;

    localparam int SW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FW   = $clog2(WINDOW + 1);
    localparam int BW   = $clog2(NUM_BINS);
    localparam int CSW  = SW + CONF_W + 1;
    localparam int PW   = FW;
    localparam int DSW  = SW + DIV_W + 1;
    localparam int BLW  = $clog2(BASELINE_LENGTH + 1);
    localparam int BSW  = BLW + DIV_W;
    localparam int NW   = (DSW > BSW) ? ((DSW > CSW) ? DSW : CSW) : ((BSW > CSW) ? BSW : CSW);
    localparam int DVW  = (FW > BLW) ? FW : BLW;
    localparam int BL_SH = BSW + $clog2(BASELINE_LENGTH);
    localparam int MW    = BSW + 1;
    localparam longint unsigned BL_RECIP =
        ((64'd1 << BL_SH) + 64'(BASELINE_LENGTH) - 64'd1) / 64'(BASELINE_LENGTH);

    // ring memory
    logic [SAMPLE_W-1:0] mem_ring [WINDOW];
    logic [SAMPLE_W-1:0] r_rdata;
    logic                mem_re;
    logic [SW-1:0]       mem_raddr;
    logic                mem_we;

    t_state r_state, n_state;
    t_dop   r_dop;

    logic [CONF_W-1:0]   r_conf;
    logic                r_pos;
    logic [DIV_W-1:0]    r_div;
    logic [SW-1:0]       r_slot;
    logic [FW-1:0]       r_fill;
    logic [CSW-1:0]      r_csum [NUM_BINS];
    logic [PW-1:0]       r_pcnt [NUM_BINS];
    logic [DSW-1:0]      r_dsum;
    logic [BSW-1:0]      r_bsum;
    logic [BLW-1:0]      r_bcnt;
    logic [DIV_W-1:0]    r_bval;
    logic                r_bdone;
    logic                r_bpend;
    logic [BSW+MW-1:0]   r_bprod;
    logic [NW-1:0]       r_eacc;
    logic [BW-1:0]       r_bin;
    logic [SW-1:0]       r_scan;
    logic                r_scan_vld;
    logic [DIV_W-1:0]    r_max;
    logic [CONF_W-1:0]   r_ece;
    logic [DIV_W-1:0]    r_mean;
    logic [CONF_W-1:0]   r_cal_lim;
    logic [DIV_W-1:0]    r_div_lim;
    logic [DIV_W-1:0]    r_div_crit;
    logic                r_ovalid;
    logic [OUT_TW-1:0]   r_odata;

    logic                w_accept;
    logic                w_full;
    logic [CONF_W-1:0]   w_conf_in;
    logic [CONF_W-1:0]   w_bconf;
    logic [23:0]         w_prod;
    logic [7:0]          w_braw;
    logic [BW-1:0]       w_bidx;
    logic [BW-1:0]       w_idx;
    logic [CSW-1:0]      w_target;
    logic [CSW-1:0]      w_abs;
    logic                w_dstart;
    logic [NW-1:0]       w_dividend;
    logic [DVW-1:0]      w_divisor;
    logic                w_ddone;
    logic [NW-1:0]       w_quo;
    logic                w_load;
    logic                w_spk, w_frz, w_cal;
    logic [1:0]          w_act;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_full   = r_fill >= FW'(WINDOW);
    assign w_conf_in = (s_axis_tdata[16:0] > CONF_W'(ONE_Q16)) ? CONF_W'(ONE_Q16)
                                                               : s_axis_tdata[16:0];

    // bin of the sample touched in this state
    assign w_bconf = (r_state == S_EVICT) ? r_rdata[CONF_W-1:0] : r_conf;
    assign w_prod  = {7'd0, w_bconf} * 24'(NUM_BINS);
    assign w_braw  = w_prod[23:16];
    assign w_bidx  = (w_braw >= 8'(NUM_BINS)) ? BW'(NUM_BINS - 1) : BW'(w_braw);
    assign w_idx   = (r_state == S_ECE) ? r_bin : w_bidx;

    assign w_target = CSW'({r_pcnt[w_idx], 16'd0});
    assign w_abs    = (r_csum[w_idx] >= w_target) ? (r_csum[w_idx] - w_target)
                                                  : (w_target - r_csum[w_idx]);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_ring[r_slot] <= {r_div, r_pos, r_conf};
        end
        if (mem_re) begin
            r_rdata <= mem_ring[mem_raddr];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (w_accept) n_state = S_EVICT;
            S_EVICT:  n_state = S_ADD;
            S_ADD:    n_state = S_ECE;
            S_ECE:    if (r_bin == BW'(NUM_BINS - 1)) n_state = S_SCAN;
            S_SCAN:   if (FW'(r_scan) == r_fill - 1'b1) n_state = S_DSTART;
            S_DSTART: n_state = S_DWAIT;
            S_DWAIT: begin
                if (w_ddone) begin
                    if (r_dop == OP_ECE) begin
                        n_state = S_DSTART;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT:    if (w_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        mem_re        = 1'b0;
        mem_raddr     = r_slot;
        mem_we        = 1'b0;
        w_dstart      = 1'b0;
        w_load        = 1'b0;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                mem_re        = w_accept;
            end
            S_EVICT:  mem_we = 1'b1;
            S_SCAN: begin
                mem_re    = 1'b1;
                mem_raddr = r_scan;
            end
            S_DSTART: w_dstart = 1'b1;
            S_OUT:    w_load = !r_ovalid || m_axis_tready;
            default: ;
        endcase
    end

    always_comb begin
        case (r_dop)
            OP_ECE:  w_dividend = NW'(r_eacc);
            OP_MEAN: w_dividend = NW'(r_dsum);
            default: w_dividend = '0;
        endcase
        w_divisor = DVW'(r_fill);
    end

    wdcm_div #(.NW(NW), .DW(DVW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_dstart),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_ddone),
        .o_quotient (w_quo)
    );

    // alert decision
    always_comb begin
        w_spk = 1'b0;
        w_frz = 1'b0;
        w_cal = 1'b0;
        w_act = ACT_NONE;
        if (r_fill >= FW'(ALERT_MIN_FILL)) begin
            w_spk = r_bdone && (r_bval != '0) && ({1'b0, r_mean} > {r_bval, 1'b0});
            if (w_spk || r_mean >= r_div_crit) begin
                w_act = ACT_EMERG;
                w_frz = 1'b1;
                w_cal = 1'b1;
            end else begin
                w_frz = r_mean > r_div_lim;
                w_cal = r_ece > r_cal_lim;
                w_act = w_frz ? ACT_FREEZE : (w_cal ? ACT_CAL : ACT_NONE);
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_dop      <= OP_ECE;
            r_slot     <= '0;
            r_fill     <= '0;
            r_dsum     <= '0;
            r_bsum     <= '0;
            r_bcnt     <= '0;
            r_bval     <= '0;
            r_bdone    <= 1'b0;
            r_bpend    <= 1'b0;
            r_scan_vld <= 1'b0;
            r_ovalid   <= 1'b0;
            r_cal_lim  <= CONF_W'(1311);
            r_div_lim  <= DIV_W'(22938);
            r_div_crit <= DIV_W'(32768);
            for (int k = 0; k < NUM_BINS; k++) begin
                r_csum[k] <= '0;
                r_pcnt[k] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_scan_vld <= (r_state == S_SCAN);
            if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CAL_LIMIT: r_cal_lim  <= i_cfg_data[CONF_W-1:0];
                    REG_DIV_LIMIT: r_div_lim  <= i_cfg_data;
                    REG_DIV_CRIT:  r_div_crit <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_EVICT: begin
                    if (w_full) begin
                        r_csum[w_idx] <= r_csum[w_idx] - CSW'(r_rdata[CONF_W-1:0]);
                        r_pcnt[w_idx] <= r_pcnt[w_idx] - PW'(r_rdata[CONF_W]);
                        r_dsum        <= r_dsum - DSW'(r_rdata[SAMPLE_W-1:CONF_W+1]);
                    end
                end
                S_ADD: begin
                    r_csum[w_idx] <= r_csum[w_idx] + CSW'(r_conf);
                    r_pcnt[w_idx] <= r_pcnt[w_idx] + PW'(r_pos);
                    r_dsum        <= r_dsum + DSW'(r_div);
                    r_slot        <= (r_slot == SW'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
                    if (!w_full) begin
                        r_fill <= r_fill + 1'b1;
                    end
                    if (!r_bdone) begin
                        r_bsum <= r_bsum + BSW'(r_div);
                        r_bcnt <= r_bcnt + 1'b1;
                        if (r_bcnt + 1'b1 >= BLW'(BASELINE_LENGTH)) begin
                            r_bpend <= 1'b1;
                        end
                    end
                    r_dop <= OP_ECE;
                end
                S_DWAIT: begin
                    if (w_ddone) begin
                        case (r_dop)
                            OP_ECE:  r_dop <= OP_MEAN;
                            OP_MEAN: begin
                                if (r_bpend) begin
                                    r_bval  <= r_bprod[BL_SH +: DIV_W];
                                    r_bdone <= 1'b1;
                                    r_bpend <= 1'b0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_conf <= w_conf_in;
            r_pos  <= s_axis_tdata[17];
            r_div  <= s_axis_tdata[41:18];
        end
        if (r_state == S_ADD) begin
            r_eacc <= '0;
            r_bin  <= '0;
            r_max  <= '0;
        end
        if (r_state == S_ECE) begin
            r_eacc  <= r_eacc + NW'(w_abs);
            r_bin   <= r_bin + 1'b1;
            r_scan  <= '0;
            r_bprod <= r_bsum * MW'(BL_RECIP);
        end
        if (r_state == S_SCAN) begin
            r_scan <= r_scan + 1'b1;
        end
        if (r_scan_vld && r_rdata[SAMPLE_W-1:CONF_W+1] > r_max) begin
            r_max <= r_rdata[SAMPLE_W-1:CONF_W+1];
        end
        if (r_state == S_DWAIT && w_ddone) begin
            if (r_dop == OP_ECE) r_ece <= w_quo[CONF_W-1:0];
            if (r_dop == OP_MEAN) r_mean <= w_quo[DIV_W-1:0];
        end
        if (w_load) begin
            r_odata <= {FILL_W'(r_fill), r_max, r_mean, r_ece, r_bdone, w_spk, w_frz,
                        w_cal, w_act};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    `WDCM_ASSERT_NOW(a_slot_range, 1'b1, r_slot < SW'(WINDOW))
    `WDCM_ASSERT_NOW(a_fill_tracks_slot, r_fill < FW'(WINDOW), FW'(r_slot) == r_fill)
    `WDCM_ASSERT_NEXT(a_load_sets_valid, w_load, m_axis_tvalid)
    `WDCM_ASSERT_NOW(a_base_once, r_bpend, !r_bdone)
endmodule
